// ----- src/best_fit_partition_allocator_macros.svh -----
`ifndef BEST_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_MACROS_SVH

// same-cycle implication, checks held off while in reset
`define BFPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checks held off while in reset
`define BFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bfpa_pkg.sv -----
package bfpa_pkg;

    localparam int DEF_PARTITIONS = 8;
    localparam int DEF_ADDR_BITS  = 16;

    localparam int OP_W     = 2;
    localparam int INDEX_W  = 3;
    localparam int OWNER_W  = 6;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 4;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 2'd0,
        ST_TOO_BIG = 2'd1,
        ST_FULL    = 2'd2,
        ST_DONE    = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic write_entry;
        logic rd_en;
        logic proc_en;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } t_sts;

endpackage

// ----- src/bfpa_ctrl.sv -----
`include "best_fit_partition_allocator_macros.svh"

module bfpa_ctrl #(
    parameter int   PARTITIONS = bfpa_pkg::DEF_PARTITIONS,
    localparam int  IDX_W      = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1,
    localparam int  CNT_W      = $clog2(PARTITIONS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CNT_W-1:0]  i_live,
    input  bfpa_pkg::t_sts    i_sts,
    output bfpa_pkg::t_cmd    o_cmd,
    output logic [IDX_W-1:0]  o_rd_addr,
    output logic [IDX_W-1:0]  o_proc_idx
);
    import bfpa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WRITE = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_addr, n_addr;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pidx;
    logic               accept;
    logic               rd_go;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign rd_go      = (r_state == S_SCAN) && (r_addr < i_live);
    assign o_rd_addr  = r_addr[IDX_W-1:0];
    assign o_proc_idx = r_pidx;

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_addr        = '0;
                    n_state       = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_entry = 1'b1;
                n_state           = S_SCAN;
            end
            S_SCAN: begin
                if (rd_go) begin
                    o_cmd.rd_en = 1'b1;
                    n_addr      = r_addr + CNT_W'(1);
                end else if (!r_pend) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_sts.out_full) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // read data lands in the cycle after the address
        o_cmd.proc_en = r_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pend  <= rd_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_addr[IDX_W-1:0];
    end

    `BFPA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state == S_WRITE, "accepted word did not start")
    `BFPA_ASSERT_NOW(a_commit_in_fin, i_clk, i_rst_n, o_cmd.commit, r_state == S_FIN && !i_sts.out_full, "commit outside finish")
    `BFPA_ASSERT_NOW(a_scan_bounded, i_clk, i_rst_n, r_state == S_SCAN, r_addr <= i_live, "scan ran past live entries")
    `BFPA_ASSERT_NEXT(a_fin_waits, i_clk, i_rst_n, r_state == S_FIN && i_sts.out_full, r_state == S_FIN, "finish left with output full")

endmodule

// ----- src/bfpa_dp.sv -----
module bfpa_dp #(
    parameter int   PARTITIONS = bfpa_pkg::DEF_PARTITIONS,
    parameter int   ADDR_BITS  = bfpa_pkg::DEF_ADDR_BITS,
    localparam int  IDX_W      = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1,
    localparam int  CNT_W      = $clog2(PARTITIONS + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bfpa_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  bfpa_pkg::t_cmd                 i_cmd,
    output bfpa_pkg::t_sts                 o_sts,
    output logic [CNT_W-1:0]               o_live,
    input  logic [IDX_W-1:0]               i_rd_addr,
    input  logic [IDX_W-1:0]               i_proc_idx,
    input  logic [bfpa_pkg::OP_W-1:0]      i_op,
    input  logic [bfpa_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic [ADDR_BITS-1:0]           i_base_address,
    input  logic [ADDR_BITS-1:0]           i_entry_size,
    input  logic [ADDR_BITS-1:0]           i_request_size,
    input  logic [bfpa_pkg::OWNER_W-1:0]   i_owner_id,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bfpa_pkg::STATUS_W-1:0]  o_status,
    output logic [bfpa_pkg::INDEX_W-1:0]   o_granted_index,
    output logic [ADDR_BITS-1:0]           o_granted_base,
    output logic [ADDR_BITS-1:0]           o_granted_size,
    output logic [bfpa_pkg::COUNT_W-1:0]   o_released_count,
    output logic [bfpa_pkg::COUNT_W-1:0]   o_free_count
);
    import bfpa_pkg::*;

    logic [CFG_W-1:0]       r_active;

    t_op                    r_op;
    logic [INDEX_W-1:0]     r_idx;
    logic [ADDR_BITS-1:0]   r_base, r_esize, r_req;
    logic [OWNER_W-1:0]     r_owner;

    logic [ADDR_BITS-1:0]   mem_base  [PARTITIONS];
    logic [ADDR_BITS-1:0]   mem_size  [PARTITIONS];
    logic [OWNER_W-1:0]     mem_owner [PARTITIONS];
    logic [PARTITIONS-1:0]  r_busy;
    logic [ADDR_BITS-1:0]   r_rd_base, r_rd_size;
    logic [OWNER_W-1:0]     r_rd_owner;

    logic [ADDR_BITS-1:0]   r_biggest;
    logic                   r_found;
    logic [IDX_W-1:0]       r_best_idx;
    logic [ADDR_BITS-1:0]   r_best_left, r_best_base, r_best_size;
    logic [CNT_W-1:0]       r_free, r_rel;

    logic                   r_out_valid;
    t_status                r_status, n_status;
    logic [INDEX_W-1:0]     r_gidx, n_gidx;
    logic [ADDR_BITS-1:0]   r_gbase, n_gbase, r_gsize, n_gsize;
    logic [COUNT_W-1:0]     r_relcnt, n_relcnt, r_freecnt, n_freecnt;

    logic                   idx_ok;
    logic [IDX_W-1:0]       wr_idx;
    logic                   load_write;
    logic                   cur_busy, fits, better, owner_hit;
    logic [ADDR_BITS-1:0]   left;
    logic                   too_big, grant;

    assign o_live = (32'(r_active) > PARTITIONS) ? CNT_W'(PARTITIONS) : CNT_W'(r_active);

    assign idx_ok     = 32'(r_idx) < PARTITIONS;
    assign wr_idx     = IDX_W'(r_idx);
    assign load_write = i_cmd.write_entry && (r_op == OP_LOAD) && idx_ok;

    // one entry under test per cycle
    assign cur_busy  = r_busy[i_proc_idx];
    assign fits      = r_rd_size >= r_req;
    assign left      = r_rd_size - r_req;
    assign better    = !r_found || (left < r_best_left)
                       || ((left == r_best_left) && (r_rd_base < r_best_base));
    assign owner_hit = cur_busy && (r_rd_owner == r_owner);

    assign too_big = r_req > r_biggest;
    assign grant   = (r_op == OP_ALLOC) && !too_big && r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_op);
            r_idx   <= i_entry_index;
            r_base  <= i_base_address;
            r_esize <= i_entry_size;
            r_req   <= i_request_size;
            r_owner <= i_owner_id;
        end
    end

    // partition table
    always_ff @(posedge i_clk) begin
        if (load_write) begin
            mem_base[wr_idx] <= r_base;
            mem_size[wr_idx] <= r_esize;
        end
        if (i_cmd.commit && grant) begin
            mem_owner[r_best_idx] <= r_owner;
        end
        if (i_cmd.rd_en) begin
            r_rd_base  <= mem_base[i_rd_addr];
            r_rd_size  <= mem_size[i_rd_addr];
            r_rd_owner <= mem_owner[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else begin
            if (load_write) begin
                r_busy[wr_idx] <= 1'b0;
            end
            if (i_cmd.proc_en && (r_op == OP_RELEASE) && owner_hit) begin
                r_busy[i_proc_idx] <= 1'b0;
            end
            if (i_cmd.commit && grant) begin
                r_busy[r_best_idx] <= 1'b1;
            end
        end
    end

    // running best fit, largest size and counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_biggest <= '0;
            r_found   <= 1'b0;
            r_free    <= '0;
            r_rel     <= '0;
        end else if (i_cmd.proc_en) begin
            if (r_op == OP_ALLOC) begin
                if (r_rd_size > r_biggest) begin
                    r_biggest <= r_rd_size;
                end
                if (!cur_busy && fits && better) begin
                    r_found     <= 1'b1;
                    r_best_idx  <= i_proc_idx;
                    r_best_left <= left;
                    r_best_base <= r_rd_base;
                    r_best_size <= r_rd_size;
                end
            end
            if ((r_op == OP_RELEASE) && owner_hit) begin
                r_rel <= r_rel + CNT_W'(1);
            end
            if (!cur_busy || ((r_op == OP_RELEASE) && owner_hit)) begin
                r_free <= r_free + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_status  = ST_DONE;
        n_gidx    = '0;
        n_gbase   = '0;
        n_gsize   = '0;
        n_relcnt  = COUNT_W'(r_rel);
        n_freecnt = COUNT_W'(r_free);
        if (r_op == OP_ALLOC) begin
            if (too_big) begin
                n_status = ST_TOO_BIG;
            end else if (!r_found) begin
                n_status = ST_FULL;
            end else begin
                n_status  = ST_GRANTED;
                n_gidx    = INDEX_W'(r_best_idx);
                n_gbase   = r_best_base;
                n_gsize   = r_best_size;
                n_freecnt = COUNT_W'(r_free - CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status  <= n_status;
            r_gidx    <= n_gidx;
            r_gbase   <= n_gbase;
            r_gsize   <= n_gsize;
            r_relcnt  <= n_relcnt;
            r_freecnt <= n_freecnt;
        end
    end

    assign o_sts.out_full    = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_index   = r_gidx;
    assign o_granted_base    = r_gbase;
    assign o_granted_size    = r_gsize;
    assign o_released_count  = r_relcnt;
    assign o_free_count      = r_freecnt;

endmodule

// ----- src/best_fit_partition_allocator.sv -----
// channel   direction  handshake                   word
// in        input      i_in_valid / o_in_ready     op, index, base, size, request, owner
// out       output     o_out_valid / i_out_ready   status, grant, released and free counts
// cfg       input      i_cfg_we (no wait)          active partition count
//
// an item's result follows a sweep of the table memory through its read port, one entry a cycle,
// over the n live entries, n being the live entry count (at most PARTITIONS)
// one item at a time; the next word is taken once the previous result sits in the output register
// a result waiting on a stalled output holds the finishing item, not the one already delivered
// synchronous active-low reset clears busy flags, count register and control; no clearing pass

module best_fit_partition_allocator #(
    parameter int PARTITIONS = bfpa_pkg::DEF_PARTITIONS,
    parameter int ADDR_BITS  = bfpa_pkg::DEF_ADDR_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [bfpa_pkg::CFG_W-1:0]     i_cfg_wdata,
    // input words
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bfpa_pkg::OP_W-1:0]      i_op,
    input  logic [bfpa_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic [ADDR_BITS-1:0]           i_base_address,
    input  logic [ADDR_BITS-1:0]           i_entry_size,
    input  logic [ADDR_BITS-1:0]           i_request_size,
    input  logic [bfpa_pkg::OWNER_W-1:0]   i_owner_id,
    // result words
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bfpa_pkg::STATUS_W-1:0]  o_status,
    output logic [bfpa_pkg::INDEX_W-1:0]   o_granted_index,
    output logic [ADDR_BITS-1:0]           o_granted_base,
    output logic [ADDR_BITS-1:0]           o_granted_size,
    output logic [bfpa_pkg::COUNT_W-1:0]   o_released_count,
    output logic [bfpa_pkg::COUNT_W-1:0]   o_free_count
);
    import bfpa_pkg::*;

    localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CNT_W = $clog2(PARTITIONS + 1);

    t_cmd              cmd;
    t_sts              sts;
    logic [CNT_W-1:0]  live;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  proc_idx;

    // sequencer: capture, optional entry write, sweep, finish
    bfpa_ctrl #(
        .PARTITIONS (PARTITIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_live     (live),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .o_proc_idx (proc_idx)
    );

    // table, best-fit tracker, counters and output register
    bfpa_dp #(
        .PARTITIONS (PARTITIONS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_live           (live),
        .i_rd_addr        (rd_addr),
        .i_proc_idx       (proc_idx),
        .i_op             (i_op),
        .i_entry_index    (i_entry_index),
        .i_base_address   (i_base_address),
        .i_entry_size     (i_entry_size),
        .i_request_size   (i_request_size),
        .i_owner_id       (i_owner_id),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_granted_index  (o_granted_index),
        .o_granted_base   (o_granted_base),
        .o_granted_size   (o_granted_size),
        .o_released_count (o_released_count),
        .o_free_count     (o_free_count)
    );

endmodule
